// File: hdl/drrp_pkg.sv
// ----------------------------------------------------------------------------
// drrp_pkg
// Shared sizes, codes and command/status types of the DNS record parser.
// ----------------------------------------------------------------------------
`default_nettype none
package drrp_pkg;

	localparam int MESSAGE_BYTES = 512;
	localparam int MAX_RECORDS   = 63;
	localparam int ADDR_W        = $clog2(MESSAGE_BYTES);
	localparam int OFF_W         = $clog2(MESSAGE_BYTES + 1);

	localparam int OUT_BITS      = 123;
	localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [OFF_W-1:0] off_t;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_NAME  = 3'd2;
	localparam logic [2:0] ST_LONG_NAME = 3'd3;
	localparam logic [2:0] ST_BAD_RDLEN = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;
	localparam logic [2:0] ST_LIMIT     = 3'd6;

	// configuration register indexes
	localparam logic CFG_MX_ONLY = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	// record types and class
	localparam logic [15:0] TYPE_A     = 16'd1;
	localparam logic [15:0] TYPE_NS    = 16'd2;
	localparam logic [15:0] TYPE_CNAME = 16'd5;
	localparam logic [15:0] TYPE_SOA   = 16'd6;
	localparam logic [15:0] TYPE_PTR   = 16'd12;
	localparam logic [15:0] TYPE_MX    = 16'd15;
	localparam logic [15:0] TYPE_AAAA  = 16'd28;
	localparam logic [15:0] CLASS_IN   = 16'd1;

	localparam logic [10:0] LEN_CAP    = 11'd2047;

	// datapath operations
	localparam logic [4:0] OP_NOP      = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_INIT     = 5'd2;
	localparam logic [4:0] OP_SHIFT    = 5'd3;
	localparam logic [4:0] OP_HDR      = 5'd4;
	localparam logic [4:0] OP_NINIT    = 5'd5;
	localparam logic [4:0] OP_NLEN     = 5'd6;
	localparam logic [4:0] OP_NPTR     = 5'd7;
	localparam logic [4:0] OP_NEND     = 5'd8;
	localparam logic [4:0] OP_ACLR     = 5'd9;
	localparam logic [4:0] OP_TSHIFT   = 5'd10;
	localparam logic [4:0] OP_SET_TYPE = 5'd11;
	localparam logic [4:0] OP_SET_CLS  = 5'd12;
	localparam logic [4:0] OP_SET_TTL  = 5'd13;
	localparam logic [4:0] OP_SET_RDL  = 5'd14;
	localparam logic [4:0] OP_SET_PREF = 5'd15;
	localparam logic [4:0] OP_OWNER    = 5'd16;
	localparam logic [4:0] OP_OPAQUE   = 5'd17;
	localparam logic [4:0] OP_ANSDEC   = 5'd18;
	localparam logic [4:0] OP_EMIT     = 5'd19;
	localparam logic [4:0] OP_SUMMARY  = 5'd20;

	// read address sources
	localparam logic [2:0] AS_OFF   = 3'd0;
	localparam logic [2:0] AS_NOFF  = 3'd1;
	localparam logic [2:0] AS_NOFF1 = 3'd2;
	localparam logic [2:0] AS_B6    = 3'd3;
	localparam logic [2:0] AS_B7    = 3'd4;

	typedef struct packed {
		logic [4:0] op;
		logic [2:0] asel;
		logic [4:0] cnt;
		logic [2:0] st;
	} cmd_t;

	typedef struct packed {
		logic overflow;
		logic len_lt12;
		logic ans_zero;
		logic off_ge_len;
		logic noff_ge_len;
		logic byte_zero;
		logic byte_ptr;
		logic ptr_bad_len;
		logic lab_bad;
		logic ptr_bad;
		logic name_long;
		logic take_short;
		logic rd_short;
		logic rdlen_bad;
		logic is_name_type;
		logic is_mx;
		logic is_soa;
		logic is_a_in;
		logic is_aaaa_in;
		logic skip;
		logic limit;
		logic out_full;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/drrp_ram.sv
// ----------------------------------------------------------------------------
// drrp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module drrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/drrp_datapath.sv
// ----------------------------------------------------------------------------
// drrp_datapath
// Message store, parse registers, checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module drrp_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [10:0]                   cfg_data,
	input  wire drrp_pkg::cmd_t                cmd,
	output drrp_pkg::sts_t                     sts,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [drrp_pkg::OUT_W-1:0]         m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);

	drrp_pkg::off_t len_q, off_q, noff_q, start_q, end_q, save_q, owner_q;
	logic        ovf_q, out_valid_q, mx_only_q;
	logic [10:0] max_len_q, elen_q;
	logic [5:0]  emitted_q;
	logic [7:0]  nb_q, rdata;
	logic [31:0] acc_q, ttl_q;
	logic [15:0] type_q, cls_q, rdlen_q, pref_q, ans_q;
	logic [drrp_pkg::OUT_W-1:0] out_data_q;
	logic        out_user_q, out_last_q;

	logic                        ram_we;
	logic [drrp_pkg::ADDR_W-1:0] raddr;
	logic [15:0]                 lab_end, ptr16;
	logic [11:0]                 elen_sum;
	logic [10:0]                 elen_lab, elen_fin;
	drrp_pkg::off_t              rem, noff1, noff2, end_lab, end_ptr, end_fin;
	logic [15:0]                 rd_off16, own_off16;

	// message store
	assign ram_we = (cmd.op == drrp_pkg::OP_LOAD) &&
		(len_q < drrp_pkg::OFF_W'(drrp_pkg::MESSAGE_BYTES));

	drrp_ram #(.WIDTH(8), .DEPTH(drrp_pkg::MESSAGE_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[drrp_pkg::ADDR_W-1:0]),
		.wdata (in_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// select read address
	always_comb begin
		unique case (cmd.asel)
			drrp_pkg::AS_NOFF:  raddr = noff_q[drrp_pkg::ADDR_W-1:0];
			drrp_pkg::AS_NOFF1: raddr = noff1[drrp_pkg::ADDR_W-1:0];
			drrp_pkg::AS_B6:    raddr = drrp_pkg::ADDR_W'(6);
			drrp_pkg::AS_B7:    raddr = drrp_pkg::ADDR_W'(7);
			default:            raddr = off_q[drrp_pkg::ADDR_W-1:0];
		endcase
	end

	// name arithmetic
	assign noff1    = noff_q + drrp_pkg::OFF_W'(1);
	assign noff2    = noff_q + drrp_pkg::OFF_W'(2);
	assign rem      = len_q - off_q;
	assign lab_end  = 16'(noff_q) + 16'(rdata) + 16'd1;
	assign ptr16    = {2'b00, nb_q[5:0], rdata};
	assign elen_sum = 12'(elen_q) + 12'(rdata) + 12'd1;
	assign elen_lab = (elen_sum > 12'(drrp_pkg::LEN_CAP)) ? drrp_pkg::LEN_CAP
		: elen_sum[10:0];
	assign elen_fin = (elen_q == drrp_pkg::LEN_CAP) ? elen_q : elen_q + 11'd1;
	assign end_lab  = (end_q < lab_end[drrp_pkg::OFF_W-1:0]) ?
		lab_end[drrp_pkg::OFF_W-1:0] : end_q;
	assign end_ptr  = (end_q < noff2) ? noff2 : end_q;
	assign end_fin  = (end_q < noff1) ? noff1 : end_q;

	// status toward the controller
	always_comb begin
		sts.overflow     = ovf_q;
		sts.len_lt12     = len_q < drrp_pkg::OFF_W'(12);
		sts.ans_zero     = ans_q == 16'd0;
		sts.off_ge_len   = off_q >= len_q;
		sts.noff_ge_len  = noff_q >= len_q;
		sts.byte_zero    = rdata == 8'd0;
		sts.byte_ptr     = rdata[7:6] == 2'b11;
		sts.ptr_bad_len  = 16'(noff_q) + 16'd2 > 16'(len_q);
		sts.lab_bad      = lab_end > 16'(len_q);
		sts.ptr_bad      = ptr16 >= 16'(start_q);
		sts.name_long    = elen_fin > max_len_q;
		sts.take_short   = 16'(rem) < 16'(cmd.cnt);
		sts.rd_short     = 16'(rem) < rdlen_q;
		sts.rdlen_bad    = 16'(off_q - save_q) != rdlen_q;
		sts.is_name_type = (type_q == drrp_pkg::TYPE_CNAME) ||
			(type_q == drrp_pkg::TYPE_NS) || (type_q == drrp_pkg::TYPE_PTR);
		sts.is_mx        = type_q == drrp_pkg::TYPE_MX;
		sts.is_soa       = type_q == drrp_pkg::TYPE_SOA;
		sts.is_a_in      = (type_q == drrp_pkg::TYPE_A) && (cls_q == drrp_pkg::CLASS_IN);
		sts.is_aaaa_in   = (type_q == drrp_pkg::TYPE_AAAA) && (cls_q == drrp_pkg::CLASS_IN);
		sts.skip         = mx_only_q && (type_q != drrp_pkg::TYPE_MX);
		sts.limit        = emitted_q >= 6'(drrp_pkg::MAX_RECORDS);
		sts.out_full     = out_valid_q;
	end

	// control registers: length, overflow, count, result valid, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
			mx_only_q   <= 1'b1;
			max_len_q   <= 11'd1025;
		end else begin
			if (cfg_we) begin
				if (cfg_index == drrp_pkg::CFG_MX_ONLY) begin
					mx_only_q <= cfg_data[0];
				end else begin
					max_len_q <= cfg_data;
				end
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				drrp_pkg::OP_LOAD: begin
					if (ram_we) len_q <= len_q + drrp_pkg::OFF_W'(1);
					else        ovf_q <= 1'b1;
				end
				drrp_pkg::OP_INIT: emitted_q <= '0;
				drrp_pkg::OP_EMIT: begin
					emitted_q   <= emitted_q + 6'd1;
					out_valid_q <= 1'b1;
				end
				drrp_pkg::OP_SUMMARY: begin
					out_valid_q <= 1'b1;
					len_q       <= '0;
					ovf_q       <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign rd_off16  = 16'(save_q);
	assign own_off16 = 16'(owner_q);

	// parse payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			drrp_pkg::OP_INIT:   begin
				off_q <= '0;
				acc_q <= '0;
			end
			drrp_pkg::OP_SHIFT:  acc_q <= {acc_q[23:0], rdata};
			drrp_pkg::OP_HDR:    begin
				ans_q <= acc_q[15:0];
				off_q <= drrp_pkg::OFF_W'(12);
			end
			drrp_pkg::OP_NINIT:  begin
				start_q <= off_q;
				end_q   <= off_q;
				noff_q  <= off_q;
				elen_q  <= '0;
			end
			drrp_pkg::OP_NLEN:   begin
				nb_q <= rdata;
				if (rdata != 8'd0 && rdata[7:6] != 2'b11) begin
					elen_q <= elen_lab;
					noff_q <= lab_end[drrp_pkg::OFF_W-1:0];
					end_q  <= end_lab;
				end
			end
			drrp_pkg::OP_NPTR:   begin
				start_q <= ptr16[drrp_pkg::OFF_W-1:0];
				noff_q  <= ptr16[drrp_pkg::OFF_W-1:0];
				end_q   <= end_ptr;
			end
			drrp_pkg::OP_NEND:   begin
				end_q  <= end_fin;
				off_q  <= end_fin;
				elen_q <= elen_fin;
			end
			drrp_pkg::OP_ACLR:   acc_q <= '0;
			drrp_pkg::OP_TSHIFT: begin
				acc_q <= {acc_q[23:0], rdata};
				off_q <= off_q + drrp_pkg::OFF_W'(1);
			end
			drrp_pkg::OP_SET_TYPE: type_q <= acc_q[15:0];
			drrp_pkg::OP_SET_CLS:  cls_q  <= acc_q[15:0];
			drrp_pkg::OP_SET_TTL:  ttl_q  <= acc_q;
			drrp_pkg::OP_SET_RDL:  begin
				rdlen_q <= acc_q[15:0];
				save_q  <= off_q;
			end
			drrp_pkg::OP_SET_PREF: pref_q <= acc_q[15:0];
			drrp_pkg::OP_OWNER:  begin
				owner_q <= off_q;
				pref_q  <= '0;
			end
			drrp_pkg::OP_OPAQUE: off_q <= off_q + rdlen_q[drrp_pkg::OFF_W-1:0];
			drrp_pkg::OP_ANSDEC: ans_q <= ans_q - 16'd1;
			drrp_pkg::OP_EMIT:   begin
				out_data_q <= drrp_pkg::OUT_W'({
					6'd0, drrp_pkg::ST_OK, own_off16[8:0],
					(type_q == drrp_pkg::TYPE_MX) ? pref_q : 16'd0,
					rd_off16[8:0], rdlen_q, ttl_q, cls_q, type_q});
				out_user_q <= 1'b0;
				out_last_q <= 1'b0;
			end
			drrp_pkg::OP_SUMMARY: begin
				out_data_q <= drrp_pkg::OUT_W'({emitted_q, cmd.st, 114'd0});
				out_user_q <= 1'b1;
				out_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	// result loads only into an empty register
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == drrp_pkg::OP_EMIT || cmd.op == drrp_pkg::OP_SUMMARY) |-> !out_valid_q)
		else $error("result loaded over a pending beat");

	// summary leaves an empty message
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == drrp_pkg::OP_SUMMARY) |=> (len_q == '0 && !ovf_q))
		else $error("message not cleared after summary");

	// each record beat counts once
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == drrp_pkg::OP_EMIT) |=> (emitted_q == $past(emitted_q) + 6'd1))
		else $error("record count did not advance");

endmodule
`default_nettype wire

// File: hdl/drrp_ctrl.sv
// ----------------------------------------------------------------------------
// drrp_ctrl
// Parse sequencer: load, header, question, answer walk, name and field fetch.
// ----------------------------------------------------------------------------
`default_nettype none
module drrp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic           s_tlast,
	output logic                s_tready,
	input  wire drrp_pkg::sts_t sts,
	output drrp_pkg::cmd_t      cmd
);

	localparam logic [4:0] S_LOAD   = 5'd0;
	localparam logic [4:0] S_HDR    = 5'd1;
	localparam logic [4:0] S_H7     = 5'd2;
	localparam logic [4:0] S_HA     = 5'd3;
	localparam logic [4:0] S_HANS   = 5'd4;
	localparam logic [4:0] S_QTAKE  = 5'd5;
	localparam logic [4:0] S_REC    = 5'd6;
	localparam logic [4:0] S_TYPE   = 5'd7;
	localparam logic [4:0] S_TYPE_L = 5'd8;
	localparam logic [4:0] S_CLS_L  = 5'd9;
	localparam logic [4:0] S_TTL_L  = 5'd10;
	localparam logic [4:0] S_RDL_L  = 5'd11;
	localparam logic [4:0] S_RDCHK  = 5'd12;
	localparam logic [4:0] S_MX_L   = 5'd13;
	localparam logic [4:0] S_SOA2   = 5'd14;
	localparam logic [4:0] S_SOA3   = 5'd15;
	localparam logic [4:0] S_OPAQUE = 5'd16;
	localparam logic [4:0] S_FIN    = 5'd17;
	localparam logic [4:0] S_EMIT   = 5'd18;
	localparam logic [4:0] S_SUM    = 5'd19;
	localparam logic [4:0] N_INIT   = 5'd20;
	localparam logic [4:0] N_RD     = 5'd21;
	localparam logic [4:0] N_LEN    = 5'd22;
	localparam logic [4:0] N_PTR    = 5'd23;
	localparam logic [4:0] N_END    = 5'd24;
	localparam logic [4:0] T_CHK    = 5'd25;
	localparam logic [4:0] T_RD     = 5'd26;
	localparam logic [4:0] T_SH     = 5'd27;

	logic [4:0] state_q, state_d, nret_q, nret_d, tret_q, tret_d;
	logic [4:0] tcnt_q, tcnt_d, k_q, k_d;
	logic [2:0] err_q, err_d;

	assign s_tready = (state_q == S_LOAD);

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		nret_d   = nret_q;
		tret_d   = tret_q;
		tcnt_d   = tcnt_q;
		k_d      = k_q;
		err_d    = err_q;
		cmd.op   = drrp_pkg::OP_NOP;
		cmd.asel = drrp_pkg::AS_OFF;
		cmd.cnt  = tcnt_q;
		cmd.st   = err_q;
		unique case (state_q)
			S_LOAD: begin
				if (s_tvalid) begin
					cmd.op = drrp_pkg::OP_LOAD;
					if (s_tlast) state_d = S_HDR;
				end
			end
			S_HDR: begin
				cmd.op   = drrp_pkg::OP_INIT;
				cmd.asel = drrp_pkg::AS_B6;
				if (sts.overflow) begin
					err_d = drrp_pkg::ST_OVERFLOW; state_d = S_SUM;
				end else if (sts.len_lt12) begin
					err_d = drrp_pkg::ST_SHORT; state_d = S_SUM;
				end else begin
					state_d = S_H7;
				end
			end
			S_H7: begin
				cmd.op   = drrp_pkg::OP_SHIFT;
				cmd.asel = drrp_pkg::AS_B7;
				state_d  = S_HA;
			end
			S_HA: begin
				cmd.op  = drrp_pkg::OP_SHIFT;
				state_d = S_HANS;
			end
			S_HANS: begin
				cmd.op  = drrp_pkg::OP_HDR;
				nret_d  = S_QTAKE;
				state_d = N_INIT;
			end
			S_QTAKE: begin
				tcnt_d = 5'd4; tret_d = S_REC; state_d = T_CHK;
			end
			S_REC: begin
				if (sts.ans_zero) begin
					err_d = drrp_pkg::ST_OK; state_d = S_SUM;
				end else begin
					cmd.op = drrp_pkg::OP_OWNER; nret_d = S_TYPE; state_d = N_INIT;
				end
			end
			S_TYPE: begin
				tcnt_d = 5'd2; tret_d = S_TYPE_L; state_d = T_CHK;
			end
			S_TYPE_L: begin
				cmd.op = drrp_pkg::OP_SET_TYPE;
				tcnt_d = 5'd2; tret_d = S_CLS_L; state_d = T_CHK;
			end
			S_CLS_L: begin
				cmd.op = drrp_pkg::OP_SET_CLS;
				tcnt_d = 5'd4; tret_d = S_TTL_L; state_d = T_CHK;
			end
			S_TTL_L: begin
				cmd.op = drrp_pkg::OP_SET_TTL;
				tcnt_d = 5'd2; tret_d = S_RDL_L; state_d = T_CHK;
			end
			S_RDL_L: begin
				cmd.op  = drrp_pkg::OP_SET_RDL;
				state_d = S_RDCHK;
			end
			S_RDCHK: begin
				// dispatch on record type
				if (sts.rd_short) begin
					err_d = drrp_pkg::ST_SHORT; state_d = S_SUM;
				end else if (sts.is_name_type) begin
					nret_d = S_FIN; state_d = N_INIT;
				end else if (sts.is_mx) begin
					tcnt_d = 5'd2; tret_d = S_MX_L; state_d = T_CHK;
				end else if (sts.is_soa) begin
					nret_d = S_SOA2; state_d = N_INIT;
				end else if (sts.is_a_in) begin
					tcnt_d = 5'd4; tret_d = S_FIN; state_d = T_CHK;
				end else if (sts.is_aaaa_in) begin
					tcnt_d = 5'd16; tret_d = S_FIN; state_d = T_CHK;
				end else begin
					state_d = S_OPAQUE;
				end
			end
			S_MX_L: begin
				cmd.op = drrp_pkg::OP_SET_PREF; nret_d = S_FIN; state_d = N_INIT;
			end
			S_SOA2: begin
				nret_d = S_SOA3; state_d = N_INIT;
			end
			S_SOA3: begin
				tcnt_d = 5'd20; tret_d = S_FIN; state_d = T_CHK;
			end
			S_OPAQUE: begin
				cmd.op = drrp_pkg::OP_OPAQUE; state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.rdlen_bad) begin
					err_d = drrp_pkg::ST_BAD_RDLEN; state_d = S_SUM;
				end else begin
					cmd.op = drrp_pkg::OP_ANSDEC;
					if (sts.skip) begin
						state_d = S_REC;
					end else if (sts.limit) begin
						err_d = drrp_pkg::ST_LIMIT; state_d = S_SUM;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (!sts.out_full) begin
					cmd.op = drrp_pkg::OP_EMIT; state_d = S_REC;
				end
			end
			S_SUM: begin
				if (!sts.out_full) begin
					cmd.op = drrp_pkg::OP_SUMMARY; state_d = S_LOAD;
				end
			end
			N_INIT: begin
				cmd.op = drrp_pkg::OP_NINIT;
				if (sts.off_ge_len) begin
					err_d = drrp_pkg::ST_BAD_NAME; state_d = S_SUM;
				end else begin
					state_d = N_RD;
				end
			end
			N_RD: begin
				cmd.asel = drrp_pkg::AS_NOFF;
				if (sts.noff_ge_len) begin
					err_d = drrp_pkg::ST_BAD_NAME; state_d = S_SUM;
				end else begin
					state_d = N_LEN;
				end
			end
			N_LEN: begin
				cmd.op   = drrp_pkg::OP_NLEN;
				cmd.asel = drrp_pkg::AS_NOFF1;
				if (sts.byte_zero) begin
					state_d = N_END;
				end else if (sts.byte_ptr) begin
					if (sts.ptr_bad_len) begin
						err_d = drrp_pkg::ST_BAD_NAME; state_d = S_SUM;
					end else begin
						state_d = N_PTR;
					end
				end else if (sts.lab_bad) begin
					err_d = drrp_pkg::ST_BAD_NAME; state_d = S_SUM;
				end else begin
					state_d = N_RD;
				end
			end
			N_PTR: begin
				// follow only backward pointers
				if (sts.ptr_bad) begin
					err_d = drrp_pkg::ST_BAD_NAME; state_d = S_SUM;
				end else begin
					cmd.op = drrp_pkg::OP_NPTR; state_d = N_RD;
				end
			end
			N_END: begin
				cmd.op = drrp_pkg::OP_NEND;
				if (sts.name_long) begin
					err_d = drrp_pkg::ST_LONG_NAME; state_d = S_SUM;
				end else begin
					state_d = nret_q;
				end
			end
			T_CHK: begin
				if (sts.take_short) begin
					err_d = drrp_pkg::ST_SHORT; state_d = S_SUM;
				end else begin
					cmd.op = drrp_pkg::OP_ACLR; k_d = tcnt_q; state_d = T_RD;
				end
			end
			T_RD: begin
				state_d = T_SH;
			end
			T_SH: begin
				cmd.op = drrp_pkg::OP_TSHIFT;
				k_d    = k_q - 5'd1;
				state_d = (k_q == 5'd1) ? tret_q : T_RD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			nret_q  <= S_LOAD;
			tret_q  <= S_LOAD;
			tcnt_q  <= '0;
			k_q     <= '0;
			err_q   <= drrp_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			nret_q  <= nret_d;
			tret_q  <= tret_d;
			tcnt_q  <= tcnt_d;
			k_q     <= k_d;
			err_q   <= err_d;
		end
	end

	// input taken only while loading
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == drrp_pkg::OP_LOAD) |-> (state_q == S_LOAD && s_tvalid))
		else $error("load command outside loading");

	// field fetch never runs without bytes left
	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_SH) |-> (k_q != 5'd0))
		else $error("field fetch with zero bytes left");

	// a beat of the last byte starts the header check
	a_last_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && s_tvalid && s_tlast) |=> (state_q == S_HDR))
		else $error("parse did not start after last byte");

endmodule
`default_nettype wire

// File: hdl/dns_response_record_parser.sv
// ----------------------------------------------------------------------------
// dns_response_record_parser
// Loads a DNS response, validates it and emits its answer records.
// ----------------------------------------------------------------------------
// A message loads one byte per cycle into a 512-byte store; the beat with
// tlast starts the parse, and no byte is taken until the summary beat has
// been placed in the output register. The parse fetches every message byte
// it inspects through the store's registered read port, and skips opaque
// rdata by advancing its offset past it. Records leave as beats with tuser
// low, then one summary beat with tuser and tlast high carrying status and
// record count. Bytes past capacity set overflow and the message is
// reported without parsing.
`default_nettype none
module dns_response_record_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // data_byte
	input  wire logic                          s_tlast,   // last_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// record_type, record_class, time_to_live, rdata_length, rdata_offset,
	// mx_preference, owner_offset, status, record_count
	output logic [drrp_pkg::OUT_W-1:0]         m_tdata,
	output logic                               m_tuser,   // is_summary
	output logic                               m_tlast,   // last_result
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [10:0]                   cfg_data
);

	drrp_pkg::cmd_t cmd;
	drrp_pkg::sts_t sts;

	drrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	drrp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
